FILE: design/rlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlc_pkg: shared types and constants for the run-length capture block
// Request codes, capture modes and the item structs of both channels.
// ----------------------------------------------------------------------------
package rlc_pkg;

    localparam int NUM_RUNS_DEFAULT = 128;
    localparam int QUEUE_DEPTH      = 4;
    localparam logic [7:0] RUN_LIMIT_RESET = 8'd255;
    localparam logic [7:0] COUNT_MAX       = 8'd255;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_ARM   = 2'd1,
        REQ_FORCE = 2'd2,
        REQ_READ  = 2'd3
    } req_code_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_WAIT    = 2'd1,
        MODE_COLLECT = 2'd2,
        MODE_FULL    = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       sample_bit;
        logic [6:0] read_index;
    } req_t;

    typedef struct packed {
        logic       run_level;
        logic [7:0] run_count;
        logic [1:0] capture_state;
        logic [7:0] runs_used;
    } res_t;

endpackage
`default_nettype wire

FILE: design/rlc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rlc_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: design/rlc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlc_front: request intake and capture control
// Runs the capture mode machine, writes closed runs to the store and
// issues reads; in the following cycle hands a finished result to the queue.
// ----------------------------------------------------------------------------
module rlc_front #(
    parameter int NUM_RUNS = rlc_pkg::NUM_RUNS_DEFAULT
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire rlc_pkg::req_t s_data,
    input  wire logic [7:0]    run_limit,
    input  wire logic          q_room,
    output logic               push_valid,
    output rlc_pkg::res_t      push_data
);

    localparam int AW = $clog2(NUM_RUNS);
    localparam int PW = $clog2(NUM_RUNS + 1);
    localparam int IW = (AW > 7) ? AW : 7;
    localparam int CW = (IW > PW) ? IW : PW;

    rlc_pkg::mode_t mode_reg, mode_next;
    logic           last_valid_reg, last_valid_next;
    logic           last_bit_reg, last_bit_next;
    logic [PW-1:0]  wp_reg, wp_next;
    logic           level_reg, level_next;
    logic [7:0]     count_reg, count_next;

    logic           meta_valid_reg;
    logic           hit_reg;
    logic [1:0]     state_reg;
    logic [7:0]     used_reg;

    logic           accept;
    logic           bit_in;
    logic [PW-1:0]  wp_inc;
    logic           store_full;
    logic [7:0]     cnt_inc;
    logic           run_open, same_level;
    logic           sat_close, chg_close;
    logic           wait_change;
    logic [IW-1:0]  idx_ext;
    logic           hit;
    logic           we;
    logic [8:0]     wdata;
    logic [8:0]     rdata;

    assign s_ready = q_room;
    assign accept  = s_valid && s_ready;
    assign bit_in  = s_data.sample_bit;

    // run bookkeeping shared by the mode machine and the datapath
    assign wp_inc      = wp_reg + PW'(1);
    assign store_full  = (wp_inc == PW'(NUM_RUNS));
    assign cnt_inc     = (count_reg != rlc_pkg::COUNT_MAX) ? count_reg + 8'd1 : count_reg;
    assign run_open    = (count_reg != 8'd0);
    assign same_level  = (bit_in == level_reg);
    assign sat_close   = run_open && same_level && (cnt_inc >= run_limit);
    assign chg_close   = run_open && !same_level;
    assign wait_change = last_valid_reg && (last_bit_reg != bit_in);
    assign idx_ext     = IW'(s_data.read_index);
    assign hit         = (CW'(idx_ext) < CW'(wp_reg));

    // next mode
    always_comb begin
        mode_next = mode_reg;
        if (accept) begin
            unique case (s_data.req_type)
                rlc_pkg::REQ_TICK: begin
                    if (mode_reg == rlc_pkg::MODE_WAIT && wait_change) begin
                        mode_next = rlc_pkg::MODE_COLLECT;
                    end else if (mode_reg == rlc_pkg::MODE_COLLECT &&
                                 (sat_close || chg_close) && store_full) begin
                        mode_next = rlc_pkg::MODE_FULL;
                    end
                end
                rlc_pkg::REQ_ARM: begin
                    mode_next = rlc_pkg::MODE_WAIT;
                end
                rlc_pkg::REQ_FORCE: begin
                    if (mode_reg == rlc_pkg::MODE_WAIT) begin
                        mode_next = rlc_pkg::MODE_COLLECT;
                    end
                end
                rlc_pkg::REQ_READ: begin
                    mode_next = mode_reg;
                end
                default: begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // run datapath and store writes
    always_comb begin
        last_valid_next = last_valid_reg;
        last_bit_next   = last_bit_reg;
        wp_next         = wp_reg;
        level_next      = level_reg;
        count_next      = count_reg;
        we              = 1'b0;
        wdata           = {level_reg, count_reg};
        if (accept) begin
            unique case (s_data.req_type)
                rlc_pkg::REQ_TICK: begin
                    if (mode_reg == rlc_pkg::MODE_WAIT) begin
                        last_valid_next = 1'b1;
                        last_bit_next   = bit_in;
                        if (wait_change) begin
                            level_next = bit_in;
                            count_next = 8'd1;
                        end
                    end else if (mode_reg == rlc_pkg::MODE_COLLECT) begin
                        if (!run_open) begin
                            level_next = bit_in;
                            count_next = 8'd1;
                        end else if (same_level) begin
                            if (sat_close) begin
                                we         = 1'b1;
                                wdata      = {level_reg, cnt_inc};
                                wp_next    = wp_inc;
                                count_next = 8'd0;
                            end else begin
                                count_next = cnt_inc;
                            end
                        end else begin
                            we         = 1'b1;
                            wp_next    = wp_inc;
                            count_next = 8'd0;
                            // sample that fills the store is dropped
                            if (!store_full) begin
                                level_next = bit_in;
                                count_next = 8'd1;
                            end
                        end
                    end
                end
                rlc_pkg::REQ_ARM: begin
                    last_valid_next = 1'b0;
                    wp_next         = '0;
                    level_next      = 1'b0;
                    count_next      = 8'd0;
                end
                rlc_pkg::REQ_FORCE: begin
                    if (mode_reg == rlc_pkg::MODE_WAIT) begin
                        count_next = 8'd0;
                    end
                end
                rlc_pkg::REQ_READ: begin
                    count_next = count_reg;
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= rlc_pkg::MODE_IDLE;
            last_valid_reg <= 1'b0;
            last_bit_reg   <= 1'b0;
            wp_reg         <= '0;
            level_reg      <= 1'b0;
            count_reg      <= 8'd0;
            meta_valid_reg <= 1'b0;
        end else begin
            mode_reg       <= mode_next;
            last_valid_reg <= last_valid_next;
            last_bit_reg   <= last_bit_next;
            wp_reg         <= wp_next;
            level_reg      <= level_next;
            count_reg      <= count_next;
            meta_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg   <= (s_data.req_type == rlc_pkg::REQ_READ) && hit;
        state_reg <= mode_next;
        used_reg  <= 8'(wp_next);
    end

    rlc_ram #(
        .WIDTH (9),
        .DEPTH (NUM_RUNS)
    ) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (wp_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (idx_ext[AW-1:0]),
        .rdata (rdata)
    );

    assign push_valid              = meta_valid_reg;
    assign push_data.run_level     = hit_reg ? rdata[8] : 1'b0;
    assign push_data.run_count     = hit_reg ? rdata[7:0] : 8'd0;
    assign push_data.capture_state = state_reg;
    assign push_data.runs_used     = used_reg;

endmodule
`default_nettype wire

FILE: design/rlc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlc_queue: result queue and output side
// Small FIFO of finished results; drives the result channel and reports
// room for one more item in flight.
// ----------------------------------------------------------------------------
module rlc_queue #(
    parameter int DEPTH = rlc_pkg::QUEUE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    input  wire rlc_pkg::res_t push_data,
    output logic               room,
    output logic               m_valid,
    input  wire logic          m_ready,
    output rlc_pkg::res_t      m_data
);

    localparam int PTRW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    rlc_pkg::res_t   slots [DEPTH];
    logic [PTRW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTRW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            pop;

    assign m_valid = (count_reg != '0);
    assign m_data  = slots[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    // an item accepted now lands here next cycle
    assign room    = ((CNTW + 1)'(count_reg) + (CNTW + 1)'(push_valid)) < (CNTW + 1)'(DEPTH);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid) begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTRW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTRW'(1);
        end
        if (push_valid && !pop) begin
            count_next = count_reg + CNTW'(1);
        end else if (pop && !push_valid) begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

FILE: design/run_length_capture.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// run_length_capture: one-channel logic analyzer with run-length store
//
// Requests come in on s_valid/s_ready/s_data: sample tick, arm, force
// trigger or read of one stored (level, count) pair. Every request gives
// exactly one result on m_valid/m_ready/m_data: the addressed pair for a
// read (zero otherwise or out of range), the capture mode after the
// request and the number of stored pairs.
// A result is registered in the front and then stored in the result queue.
// Throughput is one item per cycle while the queue has room, set by the
// per-request run counter update and the one write / one read port of the
// pair store. When the receiver stalls, up to 4 results queue up; s_ready
// drops only when the queue plus the item in flight would fill it.
// run_limit is written on cfg_valid/cfg_data (cfg_ready is always high)
// and should change only while the block is idle.
// Reset (aresetn low, synchronous) sets mode idle, empties the store and
// the queue, and sets run_limit to 255. No clearing pass is needed: pairs
// beyond the fill count always read as zero.
// ----------------------------------------------------------------------------
module run_length_capture #(
    parameter int NUM_RUNS = rlc_pkg::NUM_RUNS_DEFAULT
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire rlc_pkg::req_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output rlc_pkg::res_t      m_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [7:0]    cfg_data
);

    logic [7:0]    run_limit_reg;
    logic          q_room;
    logic          push_valid;
    rlc_pkg::res_t push_data;

    // config register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_limit_reg <= rlc_pkg::RUN_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            run_limit_reg <= cfg_data;
        end
    end

    // front: mode machine, run counter and pair store
    rlc_front #(
        .NUM_RUNS (NUM_RUNS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .run_limit  (run_limit_reg),
        .q_room     (q_room),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    // back: result queue feeding the output channel
    rlc_queue #(
        .DEPTH (rlc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .room       (q_room),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // every accepted item yields its result in the following cycle
    a_accept_push: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> push_valid)
        else $error("accepted item produced no result");

    // a nonzero stored count is only visible once capture has been armed
    a_count_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid && (push_data.run_count != 8'd0) |->
        (push_data.capture_state != rlc_pkg::MODE_IDLE))
        else $error("pair read back while never armed");

    // reset leaves nothing pending on the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule
`default_nettype wire

FILE: sim/tb_run_length_capture.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_run_length_capture: self-checking bench for the run-length capture block
// Drives requests with random gaps and stalls the result channel at random.
// Every accepted request is run through a local capture model; each result
// is compared field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_run_length_capture;

    localparam int         NUM_RUNS    = rlc_pkg::NUM_RUNS_DEFAULT;
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         PHASE_ITEMS = 210;
    localparam logic [1:0] SAMPLE_NONE = 2'd2;  // no previous sample seen yet

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic          aclk = 1'b0;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    rlc_pkg::req_t s_data;
    logic          m_valid;
    logic          m_ready = 1'b0;
    rlc_pkg::res_t m_data;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [7:0]    cfg_data;

    run_length_capture #(
        .NUM_RUNS (NUM_RUNS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 2 ns period
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Capture model state: our own copy of what the block should hold
    // ------------------------------------------------------------------------
    logic [7:0]     cap_limit;
    rlc_pkg::mode_t cap_mode;
    logic [1:0]     cap_last;
    int             cap_wpos;
    logic           cap_level;
    logic [7:0]     cap_count;          // 0: no run open
    logic           pair_level [NUM_RUNS];
    logic [7:0]     pair_count [NUM_RUNS];

    rlc_pkg::res_t  expected_results [$];
    rlc_pkg::res_t  want_res;

    int  n_errors     = 0;
    int  results_seen = 0;
    int  items_sent   = 0;
    int  cycle_count  = 0;
    int  hold_cnt     = 0;
    int  phase_stop   = 0;
    bit  gap_enable   = 1'b0;
    bit  stall_enable = 1'b0;

    // Close the open run into the store; returns 1 when the store just filled.
    function automatic bit store_pair();
        if (cap_wpos < NUM_RUNS) begin
            pair_level[cap_wpos] = cap_level;
            pair_count[cap_wpos] = cap_count;
            cap_wpos++;
        end
        cap_count = '0;
        if (cap_wpos >= NUM_RUNS) begin
            cap_mode = rlc_pkg::MODE_FULL;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // One tick while collecting: open, extend or close the current run.
    function automatic void extend_run(input logic bit_in);
        if (cap_count == '0) begin
            cap_level = bit_in;
            cap_count = 8'd1;
        end else if (bit_in == cap_level) begin
            if (cap_count < rlc_pkg::COUNT_MAX)
                cap_count++;
            // saturated run: pair stored, next tick opens a fresh run
            if (cap_count >= cap_limit)
                void'(store_pair());
        end else begin
            // level change; if the store fills, this sample is dropped
            if (!store_pair()) begin
                cap_level = bit_in;
                cap_count = 8'd1;
            end
        end
    endfunction

    // Apply one request to the model and return the result it must produce.
    function automatic rlc_pkg::res_t predict_capture(input rlc_pkg::req_t item);
        rlc_pkg::res_t r;
        r = '0;
        case (item.req_type)
            rlc_pkg::REQ_TICK: begin
                if (cap_mode == rlc_pkg::MODE_WAIT) begin
                    // first change of level starts the capture
                    if (cap_last != SAMPLE_NONE && cap_last[0] != item.sample_bit) begin
                        cap_mode  = rlc_pkg::MODE_COLLECT;
                        cap_count = '0;
                        extend_run(item.sample_bit);
                    end
                    cap_last = {1'b0, item.sample_bit};
                end else if (cap_mode == rlc_pkg::MODE_COLLECT) begin
                    extend_run(item.sample_bit);
                end
            end
            rlc_pkg::REQ_ARM: begin
                cap_mode  = rlc_pkg::MODE_WAIT;
                cap_last  = SAMPLE_NONE;
                cap_wpos  = 0;
                cap_level = 1'b0;
                cap_count = '0;
            end
            rlc_pkg::REQ_FORCE: begin
                // only meaningful while waiting; no run is opened yet
                if (cap_mode == rlc_pkg::MODE_WAIT) begin
                    cap_mode  = rlc_pkg::MODE_COLLECT;
                    cap_count = '0;
                end
            end
            default: begin
                // pairs at or beyond the fill count read as zero
                if (int'(item.read_index) < cap_wpos) begin
                    r.run_level = pair_level[item.read_index];
                    r.run_count = pair_count[item.read_index];
                end
            end
        endcase
        r.capture_state = cap_mode;
        r.runs_used     = cap_wpos[7:0];
        return r;
    endfunction

    // Idle lengths: mostly short, now and then a long one.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        if (n_errors <= 50)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     results_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Request driver. Valid is held from the previous item only when the next
    // one follows without a gap, so s_valid never sees two NBAs in one step.
    // ------------------------------------------------------------------------
    task automatic send_item(input rlc_pkg::req_code_t code, input logic bit_in,
                             input logic [6:0] idx);
        rlc_pkg::req_t item;
        int            gap;
        item.req_type   = code;
        item.sample_bit = bit_in;
        item.read_index = idx;
        gap = (gap_enable && $urandom_range(0, 1)) ? pick_pause() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(predict_capture(item));
        items_sent++;
    endtask

    // Sender stops until the block has returned every predicted result.
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // run_limit is only changed with the block drained.
    task automatic write_run_limit(input logic [7:0] value);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cap_limit = value;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random backpressure and the checker
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_cnt > 0) begin
            hold_cnt--;
        end else if (!stall_enable || $urandom_range(0, 2) != 0) begin
            m_ready <= 1'b1;
            hold_cnt = $urandom_range(0, 8);
        end else begin
            m_ready <= 1'b0;
            hold_cnt = pick_pause() - 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected, runs_used",
                                m_data.runs_used, 0);
            end else begin
                want_res = expected_results.pop_front();
                if (m_data.run_level !== want_res.run_level)
                    report_mismatch("run_level", m_data.run_level, want_res.run_level);
                if (m_data.run_count !== want_res.run_count)
                    report_mismatch("run_count", m_data.run_count, want_res.run_count);
                if (m_data.capture_state !== want_res.capture_state)
                    report_mismatch("capture_state", m_data.capture_state,
                                    want_res.capture_state);
                if (m_data.runs_used !== want_res.runs_used)
                    report_mismatch("runs_used", m_data.runs_used, want_res.runs_used);
            end
            results_seen++;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Before any arm: ticks and force are ignored, reads return zero.
    task automatic test_idle_requests();
        send_item(rlc_pkg::REQ_TICK, 1'b0, 7'd0);
        send_item(rlc_pkg::REQ_TICK, 1'b1, 7'd127);
        send_item(rlc_pkg::REQ_FORCE, 1'b1, 7'd0);
        send_item(rlc_pkg::REQ_READ, 1'b0, 7'd0);
        send_item(rlc_pkg::REQ_READ, 1'b1, 7'd127);
    endtask

    // Arm, wait for the first change, close a pair on a level change,
    // read in and out of range, force ignored while collecting, re-arm.
    task automatic test_first_change();
        send_item(rlc_pkg::REQ_ARM, 1'b0, 7'd0);
        send_item(rlc_pkg::REQ_TICK, 1'b1, 7'd0);    // first sample, nothing to compare
        send_item(rlc_pkg::REQ_TICK, 1'b1, 7'd0);    // same level, still waiting
        send_item(rlc_pkg::REQ_TICK, 1'b0, 7'd0);    // change: run of 0 opens
        send_item(rlc_pkg::REQ_TICK, 1'b0, 7'd0);
        send_item(rlc_pkg::REQ_TICK, 1'b1, 7'd0);    // pair (0,2) stored
        send_item(rlc_pkg::REQ_READ, 1'b0, 7'd0);
        send_item(rlc_pkg::REQ_READ, 1'b0, 7'd1);    // beyond fill count
        send_item(rlc_pkg::REQ_FORCE, 1'b0, 7'd0);   // no effect while collecting
        send_item(rlc_pkg::REQ_ARM, 1'b1, 7'd0);     // arm from collecting
        send_item(rlc_pkg::REQ_READ, 1'b0, 7'd0);    // store emptied
        send_item(rlc_pkg::REQ_FORCE, 1'b0, 7'd0);   // skip the wait
        send_item(rlc_pkg::REQ_TICK, 1'b1, 7'd0);    // opens a run at once
    endtask

    // run_limit of 2: every second equal tick closes a pair.
    task automatic test_run_saturation();
        write_run_limit(8'd2);
        send_item(rlc_pkg::REQ_ARM, 1'b0, 7'd0);
        send_item(rlc_pkg::REQ_FORCE, 1'b0, 7'd0);
        send_item(rlc_pkg::REQ_TICK, 1'b1, 7'd0);
        send_item(rlc_pkg::REQ_TICK, 1'b1, 7'd0);    // saturated: pair (1,2)
        send_item(rlc_pkg::REQ_TICK, 1'b1, 7'd0);    // new run
        send_item(rlc_pkg::REQ_TICK, 1'b0, 7'd0);    // change: pair (1,1)
        send_item(rlc_pkg::REQ_READ, 1'b0, 7'd0);
        send_item(rlc_pkg::REQ_READ, 1'b0, 7'd1);
    endtask

    // One capture from arm onward: either a run until the store is full or
    // a mix of runs, reads and some noise.
    task automatic run_capture_session();
        logic lvl;
        int   ops;
        int   r;
        int   len;
        int   lo;
        int   guard;
        send_item(rlc_pkg::REQ_ARM, 1'($urandom), 7'($urandom));
        lvl = 1'($urandom);
        if ($urandom_range(0, 1)) begin
            send_item(rlc_pkg::REQ_FORCE, 1'($urandom), 7'($urandom));
        end else begin
            repeat ($urandom_range(1, 4)) send_item(rlc_pkg::REQ_TICK, lvl, 7'($urandom));
            if ($urandom_range(0, 3) == 0)
                send_item(rlc_pkg::REQ_READ, 1'($urandom), 7'($urandom));
            lvl = ~lvl;
            send_item(rlc_pkg::REQ_TICK, lvl, 7'($urandom));
        end

        if ($urandom_range(0, 9) < 2) begin
            // fill the store; mostly level changes, some saturated runs
            guard = 0;
            while (cap_mode == rlc_pkg::MODE_COLLECT && guard < 2000) begin
                if ($urandom_range(0, 9) < 7)
                    lvl = ~lvl;
                send_item(rlc_pkg::REQ_TICK, lvl, 7'($urandom));
                guard++;
            end
            // full: ticks and force do nothing, reads still answer
            repeat (3) send_item(rlc_pkg::REQ_TICK, 1'($urandom), 7'($urandom));
            send_item(rlc_pkg::REQ_FORCE, 1'($urandom), 7'($urandom));
            send_item(rlc_pkg::REQ_READ, 1'($urandom), 7'd0);
            send_item(rlc_pkg::REQ_READ, 1'($urandom), 7'd127);
            send_item(rlc_pkg::REQ_READ, 1'($urandom), 7'($urandom));
        end else begin
            ops = $urandom_range(15, 60);
            repeat (ops) begin
                // keep each phase near its item budget
                if (items_sent >= phase_stop)
                    break;
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    repeat ($urandom_range(1, 6))
                        send_item(rlc_pkg::REQ_TICK, lvl, 7'($urandom));
                    if ($urandom_range(0, 4) != 0)
                        lvl = ~lvl;
                end else if (r < 60) begin
                    // run around the limit, to hit saturation exactly
                    lo  = (cap_limit > 8'd3) ? int'(cap_limit) - 2 : 1;
                    len = $urandom_range(lo, int'(cap_limit) + 3);
                    repeat (len) send_item(rlc_pkg::REQ_TICK, lvl, 7'($urandom));
                end else if (r < 85) begin
                    if (cap_wpos > 0 && $urandom_range(0, 9) < 7)
                        send_item(rlc_pkg::REQ_READ, 1'($urandom),
                                  7'($urandom_range(0, cap_wpos - 1)));
                    else
                        send_item(rlc_pkg::REQ_READ, 1'($urandom), 7'($urandom));
                end else if (r < 92) begin
                    send_item(rlc_pkg::REQ_TICK, 1'($urandom), 7'($urandom));
                end else if (r < 97) begin
                    send_item(rlc_pkg::REQ_FORCE, 1'($urandom), 7'($urandom));
                end else begin
                    send_item(rlc_pkg::REQ_ARM, 1'($urandom), 7'($urandom));
                end
            end
        end
    endtask

    // Several run_limit settings, extremes included; the first phase runs
    // with no idling on either side.
    task automatic test_random_capture();
        logic [7:0] limits [6];
        bit         paused;
        limits[0] = 8'd255;
        limits[1] = 8'd2;
        limits[2] = 8'($urandom_range(4, 254));
        limits[3] = 8'd3;
        limits[4] = 8'($urandom_range(4, 40));
        limits[5] = 8'd255;
        paused    = 1'b0;
        for (int p = 0; p < 6; p++) begin
            write_run_limit(limits[p]);
            stall_enable = (p != 0);
            phase_stop   = items_sent + PHASE_ITEMS;
            while (items_sent < phase_stop) begin
                gap_enable = (p != 0) && ($urandom_range(0, 3) != 0);
                run_capture_session();
                if (p == 2 && !paused) begin
                    // let the result queue run dry in the middle of a phase
                    wait_results_drained();
                    paused = 1'b1;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;

        cap_limit = rlc_pkg::RUN_LIMIT_RESET;
        cap_mode  = rlc_pkg::MODE_IDLE;
        cap_last  = SAMPLE_NONE;
        cap_wpos  = 0;
        cap_level = 1'b0;
        cap_count = '0;
        for (int i = 0; i < NUM_RUNS; i++) begin
            pair_level[i] = 1'b0;
            pair_count[i] = '0;
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_requests();
        write_run_limit(rlc_pkg::RUN_LIMIT_RESET);
        test_first_change();
        test_run_saturation();
        test_random_capture();

        wait_results_drained();
        repeat (8) @(posedge aclk);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
